>>> src/packbits_encoder_core_assert.svh
// Assertion macros used by the checker of the PackBits encoder.
`ifndef PACKBITS_ENCODER_CORE_ASSERT_SVH
`define PACKBITS_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pbe_pkg.sv
`default_nettype none

package pbe_pkg;

	localparam int MAX_SPAN  = 128;
	localparam int OUT_LANES = 8;
	localparam int WORD_W    = 8 * OUT_LANES;
	localparam int CNT_W     = $clog2(MAX_SPAN + 1);
	localparam int POS_W     = $clog2(MAX_SPAN);
	localparam int LANE_W    = $clog2(OUT_LANES);
	localparam int ROWS      = (MAX_SPAN + OUT_LANES - 1) / OUT_LANES;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int REM_W     = $clog2(MAX_SPAN + 2);
	localparam int BCNT_W    = 4;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	// One PackBits code waiting to be emitted.
	typedef struct packed {
		logic             is_run;
		logic [CNT_W-1:0] len;
		logic [7:0]       value;
		logic             bank;
	} pbe_code_t;

	// Everything one input item asks of the back end: one or two codes.
	typedef struct packed {
		logic      two;
		logic      last_of_stream;
		pbe_code_t first;
		pbe_code_t second;
	} pbe_cmd_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
	} pbe_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} pbe_rel_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SLOT,
		BK_LIT
	} pbe_bk_state_t;

	function automatic logic [7:0] run_header(input logic [CNT_W-1:0] n);
		logic [7:0] n8;
		n8 = 8'(n);
		return 8'd1 - n8;
	endfunction

	function automatic logic [7:0] lit_header(input logic [CNT_W-1:0] n);
		logic [7:0] n8;
		n8 = 8'(n);
		return n8 - 8'd1;
	endfunction

endpackage

`default_nettype wire

>>> src/pbe_front.sv
`default_nettype none

module pbe_front
	import pbe_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     raw_valid,
	output logic          raw_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic     stream_end,
	input  wire pbe_rel_t busy_rel,
	input  wire logic     q_full,
	output logic          q_push,
	output pbe_cmd_t      q_cmd,
	output pbe_wr_t       mem_wr
);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       prev_q;
	logic             run_q;
	logic             first_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	pbe_code_t        c0;
	pbe_code_t        end_code;
	logic             c0_v;
	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       prev_n;
	logic             run_n;
	logic             bank_n;
	logic             bank_f;
	pbe_wr_t          wr;
	logic             need_push;
	logic             accept;
	logic [1:0]       set_m;
	logic [1:0]       rel_m;

	// Classify the byte against the pending span and work out the codes it closes.
	always_comb begin
		c0      = '0;
		c0_v    = 1'b0;
		cnt_n   = count_q;
		prev_n  = prev_q;
		run_n   = run_q;
		bank_n  = bank_q;
		wr      = '0;
		wr.data = data_byte;
		if (!first_q) begin
			wr.en  = 1'b1;
			wr.bank = bank_q;
			cnt_n  = CNT_W'(1);
			prev_n = data_byte;
			run_n  = 1'b0;
		end else if (data_byte == prev_q) begin
			run_n = 1'b1;
			if (!run_q && count_q > CNT_W'(1)) begin
				// All pending bytes but the last leave as a literal; the last starts the run.
				c0_v      = 1'b1;
				c0.is_run = 1'b0;
				c0.len    = count_q - CNT_W'(1);
				c0.value  = prev_q;
				c0.bank   = bank_q;
				bank_n    = ~bank_q;
				cnt_n     = CNT_W'(2);
			end else if (count_q == CNT_W'(MAX_SPAN)) begin
				c0_v      = 1'b1;
				c0.is_run = 1'b1;
				c0.len    = count_q;
				c0.value  = prev_q;
				c0.bank   = bank_q;
				cnt_n     = CNT_W'(1);
			end else begin
				cnt_n = count_q + CNT_W'(1);
			end
		end else begin
			prev_n  = data_byte;
			run_n   = 1'b0;
			wr.en   = 1'b1;
			wr.bank = bank_q;
			wr.pos  = count_q[POS_W-1:0];
			cnt_n   = count_q + CNT_W'(1);
			if (run_q) begin
				c0_v      = 1'b1;
				c0.is_run = 1'b1;
				c0.len    = count_q;
				c0.value  = prev_q;
				c0.bank   = bank_q;
				wr.pos    = '0;
				cnt_n     = CNT_W'(1);
			end else if (count_q == CNT_W'(MAX_SPAN)) begin
				c0_v      = 1'b1;
				c0.is_run = 1'b0;
				c0.len    = count_q;
				c0.value  = prev_q;
				c0.bank   = bank_q;
				bank_n    = ~bank_q;
				wr.bank   = ~bank_q;
				wr.pos    = '0;
				cnt_n     = CNT_W'(1);
			end
		end
		end_code.is_run = run_n;
		end_code.len    = cnt_n;
		end_code.value  = prev_n;
		end_code.bank   = bank_n;
		bank_f = (stream_end && !run_n) ? ~bank_n : bank_n;
	end

	// A literal buffer still being read by the back end cannot take new bytes.
	assign need_push = c0_v || stream_end;
	assign raw_stall = (need_push && q_full) || (wr.en && busy_q[wr.bank]);
	assign accept    = raw_valid && !raw_stall;

	assign q_push               = accept && need_push;
	assign q_cmd.two            = c0_v && stream_end;
	assign q_cmd.last_of_stream = stream_end;
	assign q_cmd.first          = c0_v ? c0 : end_code;
	assign q_cmd.second         = end_code;

	always_comb begin
		mem_wr    = wr;
		mem_wr.en = wr.en && accept;
	end

	always_comb begin
		set_m = '0;
		rel_m = '0;
		if (accept) begin
			if (c0_v && !c0.is_run) begin
				set_m[c0.bank] = 1'b1;
			end
			if (stream_end && !run_n) begin
				set_m[bank_n] = 1'b1;
			end
		end
		rel_m[busy_rel.bank] = busy_rel.en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
			run_q   <= 1'b0;
			first_q <= 1'b0;
			bank_q  <= 1'b0;
			busy_q  <= '0;
		end else begin
			busy_q <= (busy_q & ~rel_m) | set_m;
			if (accept) begin
				if (stream_end) begin
					count_q <= '0;
					prev_q  <= '0;
					run_q   <= 1'b0;
					first_q <= 1'b0;
				end else begin
					count_q <= cnt_n;
					prev_q  <= prev_n;
					run_q   <= run_n;
					first_q <= 1'b1;
				end
				bank_q <= bank_f;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/pbe_cmd_queue.sv
`default_nettype none

module pbe_cmd_queue
	import pbe_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire pbe_cmd_t push_data,
	output logic          full,
	input  wire logic     pop,
	output pbe_cmd_t      pop_data,
	output logic          empty
);

	pbe_cmd_t          slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full     = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/pbe_back.sv
`default_nettype none

module pbe_back
	import pbe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire pbe_cmd_t    q_data,
	output logic             q_pop,
	input  wire pbe_wr_t     mem_wr,
	output pbe_rel_t         busy_rel,
	output logic             code_valid,
	input  wire logic        code_stall,
	output logic [WORD_W-1:0] packed_bytes,
	output logic [BCNT_W-1:0] byte_count,
	output logic             item_done,
	output logic             stream_done
);

	// Two span buffers, one row holds one output word of bytes.
	logic [OUT_LANES-1:0][7:0] held_mem [2*ROWS];

	pbe_bk_state_t     state_q;
	pbe_bk_state_t     state_d;
	pbe_cmd_t          cur_q;
	logic              slot_q;
	logic [7:0]        carry_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROW_W-1:0]  row_q;
	logic [WORD_W-1:0] rd_data_q;

	logic              code_valid_q;
	logic [WORD_W-1:0] packed_q;
	logic [BCNT_W-1:0] count_q;
	logic              item_q;
	logic              stream_q;

	pbe_code_t         code_sel;
	logic              slot_last;
	logic              word_last;
	logic              out_free;
	logic              rd_en;
	logic [ROW_W-1:0]  rd_row;
	logic              load_out;
	logic [WORD_W-1:0] word_d;
	logic [BCNT_W-1:0] cnt_d;
	logic              code_end;
	logic              lit_init;
	logic              lit_step;
	logic              slot_adv;

	function automatic logic [WORD_W-1:0] lane_mask(input logic [WORD_W-1:0] w,
			input logic [BCNT_W-1:0] n);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int i = 0; i < OUT_LANES; i++) begin
			if (BCNT_W'(i) < n) begin
				r[8*i +: 8] = w[8*i +: 8];
			end
		end
		return r;
	endfunction

	assign code_sel  = slot_q ? cur_q.second : cur_q.first;
	assign slot_last = slot_q || !cur_q.two;
	assign word_last = (rem_q <= REM_W'(OUT_LANES));
	assign out_free  = !code_valid_q || !code_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_SLOT;
				end
			end
			BK_SLOT: begin
				if (!code_sel.is_run) begin
					state_d = BK_LIT;
				end else if (out_free) begin
					state_d = slot_last ? BK_IDLE : BK_SLOT;
				end
			end
			BK_LIT: begin
				if (out_free && word_last) begin
					state_d = slot_last ? BK_IDLE : BK_SLOT;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		rd_row   = '0;
		load_out = 1'b0;
		word_d   = '0;
		cnt_d    = '0;
		code_end = 1'b0;
		lit_init = 1'b0;
		lit_step = 1'b0;
		busy_rel = '0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = !q_empty;
			end
			BK_SLOT: begin
				if (code_sel.is_run) begin
					load_out = out_free;
					code_end = 1'b1;
					word_d   = {{(WORD_W-16){1'b0}}, code_sel.value, run_header(code_sel.len)};
					cnt_d    = BCNT_W'(2);
				end else begin
					rd_en    = 1'b1;
					lit_init = 1'b1;
				end
			end
			BK_LIT: begin
				// Lane zero holds the header, later the last byte of the prior row.
				cnt_d  = word_last ? rem_q[BCNT_W-1:0] : BCNT_W'(OUT_LANES);
				word_d = lane_mask({rd_data_q[WORD_W-9:0], carry_q}, cnt_d);
				if (out_free) begin
					load_out = 1'b1;
					lit_step = 1'b1;
					code_end = word_last;
					if (!word_last) begin
						rd_en  = 1'b1;
						rd_row = row_q;
					end else begin
						busy_rel.en   = 1'b1;
						busy_rel.bank = code_sel.bank;
					end
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
		slot_adv = load_out && code_end && !slot_last;
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			held_mem[{mem_wr.bank, mem_wr.pos[POS_W-1:LANE_W]}][mem_wr.pos[LANE_W-1:0]]
				<= mem_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= held_mem[{code_sel.bank, rd_row}];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (lit_init) begin
			carry_q <= lit_header(code_sel.len);
			rem_q   <= REM_W'(code_sel.len) + REM_W'(1);
			row_q   <= ROW_W'(1);
		end else if (lit_step) begin
			carry_q <= rd_data_q[WORD_W-1 -: 8];
			rem_q   <= rem_q - REM_W'(OUT_LANES);
			row_q   <= row_q + ROW_W'(1);
		end
		if (load_out) begin
			packed_q <= word_d;
			count_q  <= cnt_d;
			item_q   <= code_end && slot_last;
			stream_q <= code_end && slot_last && cur_q.last_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			slot_q       <= 1'b0;
			code_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				slot_q <= 1'b0;
			end else if (slot_adv) begin
				slot_q <= 1'b1;
			end
			if (load_out) begin
				code_valid_q <= 1'b1;
			end else if (!code_stall) begin
				code_valid_q <= 1'b0;
			end
		end
	end

	assign code_valid   = code_valid_q;
	assign packed_bytes = packed_q;
	assign byte_count   = count_q;
	assign item_done    = item_q;
	assign stream_done  = stream_q;

endmodule

`default_nettype wire

>>> src/packbits_encoder_core.sv
// PackBits encoder, one raw byte per transfer on the raw channel.
// raw_valid/raw_stall carry data_byte and stream_end; code_valid/code_stall carry
// code words of up to eight bytes (first byte in bits 7:0, unused lanes zero),
// byte_count, item_done on the last word an input byte causes, and stream_done
// on the final word of a stream. Bytes that close no code produce no word.
// The front end takes one byte per cycle. It stalls only when the four-entry
// command queue is full, or when it must write a literal buffer that the back
// end is still reading; two literal buffers alternate.
// The back end takes a command from the queue, then emits a run code as one word
// or a literal of n bytes as ceil((n+1)/8) words, one word per cycle read from
// the buffer memory while the output does not stall. A code passes through the
// command queue, the back end's command register and the output register.
// A stalled code word holds in the output register while the next item may
// still be transferred. After stream_end the block is ready for a new stream.
// Reset empties the queue and the output register and clears all span state;
// the buffer memory needs no clearing.
`default_nettype none

module packbits_encoder_core
	import pbe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              raw_valid,
	output logic                   raw_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              stream_end,
	output logic                   code_valid,
	input  wire logic              code_stall,
	output logic [WORD_W-1:0]      packed_bytes,
	output logic [BCNT_W-1:0]      byte_count,
	output logic                   item_done,
	output logic                   stream_done
);

	pbe_rel_t busy_rel;
	pbe_wr_t  mem_wr;
	pbe_cmd_t push_cmd;
	pbe_cmd_t pop_cmd;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;

	pbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw_valid  (raw_valid),
		.raw_stall  (raw_stall),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.busy_rel   (busy_rel),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd),
		.mem_wr     (mem_wr)
	);

	pbe_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_cmd),
		.empty     (q_empty)
	);

	pbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_cmd),
		.q_pop        (q_pop),
		.mem_wr       (mem_wr),
		.busy_rel     (busy_rel),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.packed_bytes (packed_bytes),
		.byte_count   (byte_count),
		.item_done    (item_done),
		.stream_done  (stream_done)
	);

endmodule

`default_nettype wire

>>> src/pbe_checker.sv
`default_nettype none
`include "packbits_encoder_core_assert.svh"

module pbe_checker
	import pbe_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              code_valid,
	input wire logic              code_stall,
	input wire logic [WORD_W-1:0] packed_bytes,
	input wire logic [BCNT_W-1:0] byte_count,
	input wire logic              item_done,
	input wire logic              stream_done
);

	`PBE_ASSERT_NEXT(a_code_hold, clk, arst_n, code_valid && code_stall, code_valid && $stable(packed_bytes) && $stable(byte_count) && $stable(item_done) && $stable(stream_done), "stalled code word changed")
	`PBE_ASSERT_SAME(a_count_range, clk, arst_n, code_valid, byte_count != '0 && byte_count <= BCNT_W'(OUT_LANES), "byte_count out of range")
	`PBE_ASSERT_SAME(a_stream_item, clk, arst_n, code_valid && stream_done, item_done, "stream end without item end")
	`PBE_ASSERT_SAME(a_lane_zero, clk, arst_n, code_valid && byte_count == BCNT_W'(1), packed_bytes[WORD_W-1:8] == '0, "unused lanes not zero")

endmodule

bind packbits_encoder_core pbe_checker u_pbe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.code_valid   (code_valid),
	.code_stall   (code_stall),
	.packed_bytes (packed_bytes),
	.byte_count   (byte_count),
	.item_done    (item_done),
	.stream_done  (stream_done)
);

`default_nettype wire

>>> verif/packbits_encoder_core_test.sv
`default_nettype none

module packbits_encoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pbe_pkg::*;

	class packbits_scoreboard;
		typedef struct {
			logic [WORD_W-1:0] bytes;
			logic [BCNT_W-1:0] count;
			logic              item_done;
			logic              stream_done;
		} code_word_t;

		code_word_t  expected_words[$];
		logic [7:0]  span_bytes[MAX_SPAN];
		int unsigned span_len;
		logic [7:0]  run_candidate;
		bit          in_run;
		bit          stream_open;
		int unsigned errors;

		function new();
			span_len = 0;
			run_candidate = 8'h00;
			in_run = 1'b0;
			stream_open = 1'b0;
			errors = 0;
		endfunction

		function void push_span(logic [7:0] b);
			if (span_len < MAX_SPAN) begin
				span_bytes[span_len] = b;
				span_len++;
			end
		endfunction

		// Cuts one code into words of up to OUT_LANES bytes.
		function void emit_code(bit run, int unsigned n);
			logic [7:0]  code[MAX_SPAN+1];
			int unsigned len;
			int unsigned off;
			int unsigned cnt;
			code_word_t  w;
			if (n == 0)
				return;
			if (n > MAX_SPAN)
				n = MAX_SPAN;
			if (run) begin
				code[0] = 8'(1 - n);
				code[1] = span_bytes[0];
				len = 2;
			end else begin
				code[0] = 8'(n - 1);
				for (int i = 0; i < n; i++)
					code[i + 1] = span_bytes[i];
				len = n + 1;
			end
			for (off = 0; off < len; off += OUT_LANES) begin
				cnt = (len - off > OUT_LANES) ? OUT_LANES : len - off;
				w.bytes = '0;
				for (int i = 0; i < cnt; i++)
					w.bytes[8*i +: 8] = code[off + i];
				w.count = BCNT_W'(cnt);
				w.item_done = 1'b0;
				w.stream_done = 1'b0;
				expected_words.push_back(w);
			end
		endfunction

		// Predicts the code words caused by one accepted input byte.
		function void take_byte(logic [7:0] b, logic last);
			int unsigned words_before;
			code_word_t  w;
			words_before = expected_words.size();
			if (!stream_open) begin
				span_bytes[0] = b;
				span_len = 1;
				run_candidate = b;
				in_run = 1'b0;
				stream_open = 1'b1;
			end else if (b == run_candidate) begin
				// The last pending literal byte becomes the first byte of the run.
				if (!in_run && span_len > 1) begin
					emit_code(1'b0, span_len - 1);
					span_bytes[0] = span_bytes[span_len - 1];
					span_len = 1;
				end
				if (span_len >= MAX_SPAN) begin
					emit_code(1'b1, span_len);
					span_len = 0;
				end
				push_span(b);
				in_run = 1'b1;
			end else begin
				if (in_run) begin
					emit_code(1'b1, span_len);
					span_len = 0;
				end
				if (span_len >= MAX_SPAN) begin
					emit_code(1'b0, span_len);
					span_len = 0;
				end
				push_span(b);
				run_candidate = b;
				in_run = 1'b0;
			end
			if (last) begin
				emit_code(in_run, span_len);
				span_len = 0;
				run_candidate = 8'h00;
				in_run = 1'b0;
				stream_open = 1'b0;
			end
			if (expected_words.size() > words_before) begin
				w = expected_words.pop_back();
				w.item_done = 1'b1;
				w.stream_done = last;
				expected_words.push_back(w);
			end
		endfunction

		function void check_word(logic [WORD_W-1:0] bytes, logic [BCNT_W-1:0] count,
				logic idone, logic sdone);
			code_word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected code word: packed_bytes %h byte_count %0d", bytes, count);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (bytes !== w.bytes) begin
				$error("packed_bytes: expected %h, actual %h", w.bytes, bytes);
				errors++;
			end
			if (count !== w.count) begin
				$error("byte_count: expected %0d, actual %0d", w.count, count);
				errors++;
			end
			if (idone !== w.item_done) begin
				$error("item_done: expected %b, actual %b", w.item_done, idone);
				errors++;
			end
			if (sdone !== w.stream_done) begin
				$error("stream_done: expected %b, actual %b", w.stream_done, sdone);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              raw_valid = 1'b0;
	logic              raw_stall;
	logic [7:0]        data_byte = 8'h00;
	logic              stream_end = 1'b0;
	logic              code_valid;
	logic              code_stall = 1'b0;
	logic [WORD_W-1:0] packed_bytes;
	logic [BCNT_W-1:0] byte_count;
	logic              item_done;
	logic              stream_done;

	packbits_scoreboard sb = new();
	bit                 idle_on = 1'b1;
	int                 stall_left = 0;
	logic [7:0]         stream_q[$];

	packbits_encoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.raw_valid    (raw_valid),
		.raw_stall    (raw_stall),
		.data_byte    (data_byte),
		.stream_end   (stream_end),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.packed_bytes (packed_bytes),
		.byte_count   (byte_count),
		.item_done    (item_done),
		.stream_done  (stream_done)
	);

	always begin
		#10 clk = 1'b0;
		#10 clk = 1'b1;
	end

	// Presents one byte and returns at the edge where its transfer completes.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			raw_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		raw_valid <= 1'b1;
		data_byte <= b;
		stream_end <= last;
		@(posedge clk);
		while (raw_stall)
			@(posedge clk);
		sb.take_byte(b, last);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == stream_q.size() - 1);
	endtask

	// Mixes runs, full-range literals and small-alphabet stretches full of repeats.
	task automatic build_mixed_stream();
		int         target;
		int         seg_len;
		logic [7:0] v;
		stream_q.delete();
		target = $urandom_range(1, 24);
		while (stream_q.size() < target) begin
			seg_len = $urandom_range(1, 8);
			case ($urandom_range(0, 2))
				0: begin
					v = 8'($urandom);
					repeat (seg_len) stream_q.push_back(v);
				end
				1: begin
					repeat (seg_len) stream_q.push_back(8'($urandom));
				end
				default: begin
					repeat (seg_len) stream_q.push_back(8'($urandom_range(0, 3)));
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && code_valid && !code_stall)
			sb.check_word(packed_bytes, byte_count, item_done, stream_done);
		if (stall_left != 0) begin
			stall_left--;
			code_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			code_stall <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			code_stall <= 1'b0;
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int         mixed_sent;
		logic [7:0] v;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-byte streams at both extremes.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// Shortest run.
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// Pending literal flushed by a repeat, then the run closes the stream.
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h03, 1'b1);
		// Run ended by a new byte, then a literal.
		send_byte(8'h55, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		// An eight-byte literal spills into a second word.
		for (int i = 0; i < 8; i++)
			send_byte(8'(8'h11 * (i + 1)), i == 7);

		// A run one past the cap leaves a lone repeat behind.
		v = 8'($urandom);
		for (int i = 0; i < MAX_SPAN + 1; i++)
			send_byte(v, i == MAX_SPAN);

		// A literal past the cap, with no two neighbors equal.
		stream_q.delete();
		stream_q.push_back(8'($urandom));
		while (stream_q.size() < MAX_SPAN + 3) begin
			v = 8'($urandom);
			if (v != stream_q[$])
				stream_q.push_back(v);
		end
		send_stream();

		mixed_sent = 0;
		while (mixed_sent < 88) begin
			if (mixed_sent >= 48)
				idle_on = 1'b0;
			build_mixed_stream();
			send_stream();
			mixed_sent += stream_q.size();
		end
		raw_valid <= 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (sb.expected_words.size() != 0) begin
			$error("%0d code words never arrived", sb.expected_words.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
